@@ hdl/dcl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dcl_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int MAX_DIMS       = 4;
    localparam int COORD_BITS     = 16;
    localparam int IDX_BITS       = 8;
    localparam int LABEL_BITS     = 9;
    localparam int COUNT_BITS     = 9;
    localparam int RADIUS_BITS    = 34;
    localparam int MINNB_BITS     = 9;
    localparam int NPTS_BITS      = 9;
    localparam int DIMS_BITS      = 3;

    localparam int LABEL_UNCLASS  = -2;
    localparam int LABEL_NOISE    = -1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_MIN_NB = 2'd1;
    localparam logic [1:0] REG_NPTS   = 2'd2;
    localparam logic [1:0] REG_DIMS   = 2'd3;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_COUNT,
        SW_OPEN,
        SW_SEED
    } sweep_t;

    typedef enum logic [3:0] {
        ST_CLR_GO,
        ST_CLR_WAIT,
        ST_IDLE,
        ST_INIT_WAIT,
        ST_FETCH,
        ST_CHECK,
        ST_OCNT,
        ST_OPEN,
        ST_POP,
        ST_SFETCH,
        ST_STAKE,
        ST_SCNT,
        ST_SACT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic   load;
        logic   rd_label;
        logic   sweep_go;
        sweep_t mode;
        logic   sweep_all;
        logic   run_init;
        logic   fetch_i;
        logic   take_p;
        logic   mark_noise;
        logic   mark_open;
        logic   next_i;
        logic   pop;
        logic   fetch_seed;
        logic   cluster_done;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_busy;
        logic lbl_unclass;
        logic is_core;
        logic fifo_empty;
        logic i_done;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/dcl_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dcl_datapath #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire dcl_pkg::dp_cmd_t                                cmd,
    output dcl_pkg::dp_stat_t                                    stat,
    input  wire logic [dcl_pkg::IDX_BITS-1:0]                    in_index,
    input  wire logic [dcl_pkg::MAX_DIMS*dcl_pkg::COORD_BITS-1:0] in_coords,
    input  wire logic [dcl_pkg::RADIUS_BITS-1:0]                 radius_sq,
    input  wire logic [dcl_pkg::MINNB_BITS-1:0]                  min_nb,
    input  wire logic [$clog2(MAX_POINTS):0]                     n_eff,
    input  wire logic [dcl_pkg::MAX_DIMS-1:0]                    dim_en,
    output logic [$clog2(MAX_POINTS):0]                          cluster_count,
    output logic signed [$clog2(MAX_POINTS):0]                   label_rd
);
    import dcl_pkg::*;

    localparam int PW   = $clog2(MAX_POINTS);
    localparam int NW   = PW + 1;
    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * CW;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > RADIUS_BITS) ? SUMW : RADIUS_BITS;
    localparam int PTW  = MAX_DIMS * CW;

    logic [PTW-1:0]       pt_mem   [MAX_POINTS];
    logic signed [NW-1:0] lbl_mem  [MAX_POINTS];
    logic [PW-1:0]        fifo_mem [MAX_POINTS];

    logic [PTW-1:0]       pt_rd_reg;
    logic signed [NW-1:0] lbl_rd_reg;
    logic [PW-1:0]        fifo_rd_reg;
    logic [PW-1:0]        p_reg;
    logic [PTW-1:0]       p_coord_reg;

    logic                 sweep_on_reg;
    sweep_t               mode_reg;
    logic [NW-1:0]        limit_reg;
    logic [NW-1:0]        j_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PW-1:0]        j1_reg, j2_reg, j3_reg, j4_reg;
    logic signed [NW-1:0] lbl2_reg, lbl3_reg, lbl4_reg;
    logic signed [DW-1:0] diff_reg [MAX_DIMS];
    logic [SQW-1:0]       sq_reg   [MAX_DIMS];
    logic                 nbr4_reg;

    logic [NW-1:0]        cnt_reg;
    logic [NW-1:0]        i_reg;
    logic [PW-1:0]        head_reg;
    logic [NW-1:0]        fcount_reg;
    logic [NW-1:0]        cluster_reg;

    logic                 issue;
    logic [SUMW-1:0]      dist_sum;
    logic                 act_open, act_seed_un, act_seed_noise, push;
    logic                 lbl_we;
    logic [PW-1:0]        lbl_wa, lbl_ra, pt_ra, tail;
    logic signed [NW-1:0] lbl_wd, cid;
    logic [NW:0]          tail_sum;

    assign issue = sweep_on_reg && (j_reg < limit_reg);
    assign cid   = NW'(cluster_reg);

    assign act_open       = v4_reg && (mode_reg == SW_OPEN) && nbr4_reg;
    assign act_seed_un    = v4_reg && (mode_reg == SW_SEED) && nbr4_reg
                            && (lbl4_reg == NW'(LABEL_UNCLASS));
    assign act_seed_noise = v4_reg && (mode_reg == SW_SEED) && nbr4_reg
                            && (lbl4_reg == NW'(LABEL_NOISE));
    assign push           = act_open || act_seed_un;

    assign tail_sum = (NW+1)'(head_reg) + (NW+1)'(fcount_reg);
    assign tail     = (tail_sum >= (NW+1)'(MAX_POINTS)) ?
                      PW'(tail_sum - (NW+1)'(MAX_POINTS)) : PW'(tail_sum);

    always_comb begin
        dist_sum = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            dist_sum = dist_sum + SUMW'(sq_reg[d]);
        end
    end

    always_comb begin
        if (cmd.rd_label) begin
            lbl_ra = PW'(in_index);
        end else if (cmd.fetch_i) begin
            lbl_ra = i_reg[PW-1:0];
        end else begin
            lbl_ra = j_reg[PW-1:0];
        end
        if (cmd.fetch_i) begin
            pt_ra = i_reg[PW-1:0];
        end else if (cmd.fetch_seed) begin
            pt_ra = fifo_rd_reg;
        end else begin
            pt_ra = j_reg[PW-1:0];
        end
    end

    always_comb begin
        lbl_we = 1'b0;
        lbl_wa = j4_reg;
        lbl_wd = cid;
        if (issue && (mode_reg == SW_CLEAR)) begin
            lbl_we = 1'b1;
            lbl_wa = j_reg[PW-1:0];
            lbl_wd = NW'(LABEL_UNCLASS);
        end else if (cmd.mark_noise) begin
            lbl_we = 1'b1;
            lbl_wa = p_reg;
            lbl_wd = NW'(LABEL_NOISE);
        end else if (cmd.mark_open) begin
            lbl_we = 1'b1;
            lbl_wa = p_reg;
        end else if (push || act_seed_noise) begin
            lbl_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && (int'(in_index) < MAX_POINTS)) begin
            pt_mem[PW'(in_index)] <= in_coords;
        end
        pt_rd_reg <= pt_mem[pt_ra];
        if (lbl_we) begin
            lbl_mem[lbl_wa] <= lbl_wd;
        end
        lbl_rd_reg <= lbl_mem[lbl_ra];
        if (push) begin
            fifo_mem[tail] <= j4_reg;
        end
        if (cmd.pop) begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch_i) begin
            p_reg <= i_reg[PW-1:0];
        end else if (cmd.fetch_seed) begin
            p_reg <= fifo_rd_reg;
        end
        if (cmd.take_p) begin
            p_coord_reg <= pt_rd_reg;
        end
        j1_reg   <= j_reg[PW-1:0];
        j2_reg   <= j1_reg;
        j3_reg   <= j2_reg;
        j4_reg   <= j3_reg;
        lbl2_reg <= lbl_rd_reg;
        lbl3_reg <= lbl2_reg;
        lbl4_reg <= lbl3_reg;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (dim_en[d]) begin
                diff_reg[d] <= DW'($signed(pt_rd_reg[d*CW +: CW]))
                             - DW'($signed(p_coord_reg[d*CW +: CW]));
            end else begin
                diff_reg[d] <= '0;
            end
            sq_reg[d] <= SQW'(diff_reg[d] * diff_reg[d]);
        end
        nbr4_reg <= (CMPW'(dist_sum) < CMPW'(radius_sq)) && (j3_reg != p_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_on_reg <= 1'b0;
            mode_reg     <= SW_CLEAR;
            limit_reg    <= '0;
            j_reg        <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            head_reg     <= '0;
            fcount_reg   <= '0;
            cluster_reg  <= '0;
        end else begin
            if (cmd.sweep_go) begin
                sweep_on_reg <= 1'b1;
                mode_reg     <= cmd.mode;
                j_reg        <= '0;
                limit_reg    <= cmd.sweep_all ? NW'(MAX_POINTS) : n_eff;
            end else if (issue) begin
                j_reg <= j_reg + 1'b1;
            end else begin
                sweep_on_reg <= 1'b0;
            end
            v1_reg <= issue && (mode_reg != SW_CLEAR);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (cmd.sweep_go && (cmd.mode == SW_COUNT)) begin
                cnt_reg <= '0;
            end else if (v4_reg && (mode_reg == SW_COUNT) && nbr4_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.run_init) begin
                i_reg       <= '0;
                head_reg    <= '0;
                fcount_reg  <= '0;
                cluster_reg <= '0;
            end else begin
                if (cmd.next_i) begin
                    i_reg <= i_reg + 1'b1;
                end
                if (cmd.cluster_done) begin
                    cluster_reg <= cluster_reg + 1'b1;
                end
                if (cmd.pop) begin
                    head_reg   <= (int'(head_reg) == MAX_POINTS - 1) ? '0
                                  : head_reg + 1'b1;
                    fcount_reg <= fcount_reg - 1'b1;
                end else if (push) begin
                    fcount_reg <= fcount_reg + 1'b1;
                end
            end
        end
    end

    assign stat.sweep_busy  = sweep_on_reg || v1_reg || v2_reg || v3_reg || v4_reg;
    assign stat.lbl_unclass = (lbl_rd_reg == NW'(LABEL_UNCLASS));
    assign stat.is_core     = (int'(cnt_reg) >= int'(min_nb));
    assign stat.fifo_empty  = (fcount_reg == '0);
    assign stat.i_done      = (i_reg >= n_eff);

    assign cluster_count = cluster_reg;
    assign label_rd      = lbl_rd_reg;

endmodule
`default_nettype wire

@@ hdl/dcl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dcl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_opcode,
    input  wire logic              out_busy,
    input  wire dcl_pkg::dp_stat_t stat,
    output logic                   in_ready,
    output logic                   res_push,
    output dcl_pkg::dp_cmd_t       cmd
);
    import dcl_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = in_valid && !out_busy && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_GO;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR_GO:    state_next = ST_CLR_WAIT;
            ST_CLR_WAIT:  if (!stat.sweep_busy) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_opcode == OP_RUN) ? ST_INIT_WAIT : ST_RESP;
                end
            end
            ST_INIT_WAIT: if (!stat.sweep_busy) state_next = ST_FETCH;
            ST_FETCH:     state_next = stat.i_done ? ST_RESP : ST_CHECK;
            ST_CHECK:     state_next = stat.lbl_unclass ? ST_OCNT : ST_FETCH;
            ST_OCNT: begin
                if (!stat.sweep_busy) begin
                    state_next = stat.is_core ? ST_OPEN : ST_FETCH;
                end
            end
            ST_OPEN:      if (!stat.sweep_busy) state_next = ST_POP;
            ST_POP:       state_next = stat.fifo_empty ? ST_FETCH : ST_SFETCH;
            ST_SFETCH:    state_next = ST_STAKE;
            ST_STAKE:     state_next = ST_SCNT;
            ST_SCNT: begin
                if (!stat.sweep_busy) begin
                    state_next = stat.is_core ? ST_SACT : ST_POP;
                end
            end
            ST_SACT:      if (!stat.sweep_busy) state_next = ST_POP;
            ST_RESP:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            ST_CLR_GO: begin
                cmd.sweep_go  = 1'b1;
                cmd.mode      = SW_CLEAR;
                cmd.sweep_all = 1'b1;
            end
            ST_IDLE: begin
                in_ready = !out_busy;
                if (accept) begin
                    case (in_opcode)
                        OP_LOAD: cmd.load = 1'b1;
                        OP_READ: cmd.rd_label = 1'b1;
                        OP_RUN: begin
                            cmd.sweep_go = 1'b1;
                            cmd.mode     = SW_CLEAR;
                            cmd.run_init = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: cmd.fetch_i = !stat.i_done;
            ST_CHECK: begin
                if (stat.lbl_unclass) begin
                    cmd.take_p   = 1'b1;
                    cmd.sweep_go = 1'b1;
                    cmd.mode     = SW_COUNT;
                end else begin
                    cmd.next_i = 1'b1;
                end
            end
            ST_OCNT: begin
                if (!stat.sweep_busy) begin
                    if (stat.is_core) begin
                        cmd.mark_open = 1'b1;
                        cmd.sweep_go  = 1'b1;
                        cmd.mode      = SW_OPEN;
                    end else begin
                        cmd.mark_noise = 1'b1;
                        cmd.next_i     = 1'b1;
                    end
                end
            end
            ST_POP: begin
                if (stat.fifo_empty) begin
                    cmd.cluster_done = 1'b1;
                    cmd.next_i       = 1'b1;
                end else begin
                    cmd.pop = 1'b1;
                end
            end
            ST_SFETCH: cmd.fetch_seed = 1'b1;
            ST_STAKE: begin
                cmd.take_p   = 1'b1;
                cmd.sweep_go = 1'b1;
                cmd.mode     = SW_COUNT;
            end
            ST_SCNT: begin
                if (!stat.sweep_busy && stat.is_core) begin
                    cmd.sweep_go = 1'b1;
                    cmd.mode     = SW_SEED;
                end
            end
            ST_RESP: res_push = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/density_cluster_labeler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// DBSCAN labeler over a store of up to MAX_POINTS points.
// Input beats (s_axis): load a point, run clustering, or read one label.
// Each input beat yields exactly one result beat (m_axis) with the label,
// the cluster count of the last run and a range status bit.
// Configuration (radius squared, min neighbours, points, dims) is written
// over APB by the user only while the unit is idle; the unit does not enforce it.
// Load and read: the input beat passes through the response state into the
// output register; a new beat is taken only once the receiver has the result.
// Run: a label clear of the first n labels, then one pass over the point
// memory per neighbour query; every point is queried once and each core
// point takes one more pass, so the run time is set by the single read port
// of the point memory.
// One item is in work at a time; s_axis_tready is low while a run goes on
// or while a result beat waits.
// After reset all MAX_POINTS label memory entries are swept to unclassified;
// no input beat is taken during the sweep.
// A stalled receiver holds the result beat in the output register and
// blocks further input beats until it is taken.
module density_cluster_labeler_unit #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[1:0], point_index[9:2], coord_0[25:10], coord_1[41:26],
    // coord_2[57:42], coord_3[73:58], zero fill
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // point_label[8:0], clusters_found[17:9], status[18], zero fill
    output logic [23:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import dcl_pkg::*;

    localparam int NW = $clog2(MAX_POINTS) + 1;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [MINNB_BITS-1:0]  min_nb_reg;
    logic [NPTS_BITS-1:0]   npts_reg;
    logic [DIMS_BITS-1:0]   dims_reg;

    logic [NW-1:0]          n_eff;
    logic [DIMS_BITS-1:0]   dims_eff;
    logic [MAX_DIMS-1:0]    dim_en;

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic                   res_push;
    logic [NW-1:0]          cluster_count;
    logic signed [NW-1:0]   label_rd;
    logic signed [31:0]     label_ext;

    logic [1:0]             op_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic                   m_valid_reg;
    logic [23:0]            m_data_reg;

    logic                   idx_ok;
    logic [LABEL_BITS-1:0]  res_label;
    logic                   res_status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            min_nb_reg <= MINNB_BITS'(4);
            npts_reg   <= NPTS_BITS'(256);
            dims_reg   <= DIMS_BITS'(3);
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_RADIUS: radius_reg <= pwdata[RADIUS_BITS-1:0];
                REG_MIN_NB: min_nb_reg <= pwdata[MINNB_BITS-1:0];
                REG_NPTS:   npts_reg   <= pwdata[NPTS_BITS-1:0];
                REG_DIMS:   dims_reg   <= pwdata[DIMS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_RADIUS: prdata = 64'(radius_reg);
            REG_MIN_NB: prdata = 64'(min_nb_reg);
            REG_NPTS:   prdata = 64'(npts_reg);
            REG_DIMS:   prdata = 64'(dims_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        n_eff = (int'(npts_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(npts_reg);
        if (dims_reg == '0) begin
            dims_eff = DIMS_BITS'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            dims_eff = DIMS_BITS'(MAX_DIMS);
        end else begin
            dims_eff = dims_reg;
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            dim_en[d] = (d < int'(dims_eff));
        end
    end

    dcl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tdata[1:0]),
        .out_busy  (m_valid_reg),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .res_push  (res_push),
        .cmd       (cmd)
    );

    dcl_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_index      (s_axis_tdata[9:2]),
        .in_coords     (s_axis_tdata[73:10]),
        .radius_sq     (radius_reg),
        .min_nb        (min_nb_reg),
        .n_eff         (n_eff),
        .dim_en        (dim_en),
        .cluster_count (cluster_count),
        .label_rd      (label_rd)
    );

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg  <= s_axis_tdata[1:0];
            idx_reg <= s_axis_tdata[9:2];
        end
    end

    assign idx_ok     = (int'(idx_reg) < int'(n_eff));
    assign label_ext  = 32'(label_rd);
    assign res_label  = ((op_reg == OP_READ) && idx_ok) ? label_ext[LABEL_BITS-1:0] : '0;
    assign res_status = ((op_reg == OP_LOAD) || (op_reg == OP_READ)) && !idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            m_data_reg <= {5'd0, res_status, COUNT_BITS'(cluster_count), res_label};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import dcl_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NPTS = 256;
    localparam int NLOAD = 32;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [8:0] point_label;
        logic [8:0]        clusters_found;
        logic              status;
    } label_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    density_cluster_labeler_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow of the block
    logic [33:0]        radius_sq;
    logic [8:0]         min_nb;
    logic [8:0]         npts_cfg;
    logic [2:0]         dims_cfg;
    logic signed [15:0] coords [NPTS][4];
    int                 labels [NPTS];
    int                 cluster_total;

    label_result_t label_queue[$];
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            errors = 0;
    longint        cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int eff_points();
        return (npts_cfg > NPTS) ? NPTS : int'(npts_cfg);
    endfunction

    function automatic int eff_dims();
        if (dims_cfg == 0) return 1;
        return (dims_cfg > 4) ? 4 : int'(dims_cfg);
    endfunction

    function automatic void gather_neighbours(input int p, input int n, input int dims,
                                              output int nbrs[$]);
        longint sum;
        longint diff;
        nbrs = {};
        for (int j = 0; j < n; j++) begin
            if (j == p) continue;
            sum = 0;
            for (int d = 0; d < dims; d++) begin
                diff = longint'(coords[p][d]) - longint'(coords[j][d]);
                sum += diff * diff;
            end
            if (sum < longint'(radius_sq)) nbrs.insert(nbrs.size(), j);
        end
    endfunction

    function automatic void cluster_points();
        int n;
        int dims;
        int nbrs[$];
        int seeds[$];
        int cur;
        n = eff_points();
        dims = eff_dims();
        for (int i = 0; i < n; i++) labels[i] = LABEL_UNCLASS;
        cluster_total = 0;
        for (int i = 0; i < n; i++) begin
            if (labels[i] != LABEL_UNCLASS) continue;
            gather_neighbours(i, n, dims, nbrs);
            if (nbrs.size() < min_nb) begin
                labels[i] = LABEL_NOISE;
                continue;
            end
            labels[i] = cluster_total;
            seeds = {};
            foreach (nbrs[k]) begin
                labels[nbrs[k]] = cluster_total;
                if (seeds.size() < NPTS) seeds.insert(seeds.size(), nbrs[k]);
            end
            while (seeds.size() > 0) begin
                cur = seeds.pop_front();
                gather_neighbours(cur, n, dims, nbrs);
                if (nbrs.size() < min_nb) continue;
                foreach (nbrs[k]) begin
                    if (labels[nbrs[k]] == LABEL_UNCLASS) begin
                        if (seeds.size() < NPTS) seeds.insert(seeds.size(), nbrs[k]);
                        labels[nbrs[k]] = cluster_total;
                    end else if (labels[nbrs[k]] == LABEL_NOISE) begin
                        labels[nbrs[k]] = cluster_total;
                    end
                end
            end
            cluster_total++;
        end
    endfunction

    function automatic label_result_t predict_label(input logic [1:0] op, input logic [7:0] idx,
                                                    input logic signed [15:0] c [4]);
        label_result_t r;
        int lbl;
        lbl = 0;
        r.status = 1'b0;
        case (op)
            OP_LOAD: begin
                for (int d = 0; d < 4; d++) coords[idx][d] = c[d];
                r.status = (idx >= eff_points());
            end
            OP_RUN: cluster_points();
            OP_READ: begin
                if (idx >= eff_points()) r.status = 1'b1;
                else lbl = labels[idx];
            end
            default: ;
        endcase
        r.point_label = lbl[8:0];
        r.clusters_found = cluster_total[8:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        label_result_t e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (label_queue.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                errors++;
            end else begin
                e = label_queue.pop_front();
                if (m_axis_tdata[8:0] !== e.point_label) begin
                    $error("point_label exp %0d got %0d", e.point_label,
                           $signed(m_axis_tdata[8:0]));
                    errors++;
                end
                if (m_axis_tdata[17:9] !== e.clusters_found) begin
                    $error("clusters_found exp %0d got %0d", e.clusters_found,
                           m_axis_tdata[17:9]);
                    errors++;
                end
                if (m_axis_tdata[18] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[18]);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                             input logic signed [15:0] c [4]);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, c[3], c[2], c[1], c[0], idx, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        label_queue.insert(label_queue.size(), predict_label(op, idx, c));
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] idx);
        logic signed [15:0] c [4];
        foreach (c[d]) c[d] = 16'($urandom);
        send_item(op, idx, c);
    endtask

    // hold off until every result beat is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (label_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RADIUS: radius_sq = value[33:0];
            REG_MIN_NB: min_nb = value[8:0];
            REG_NPTS:   npts_cfg = value[8:0];
            default:    dims_cfg = value[2:0];
        endcase
    endtask

    task automatic configure(input logic [33:0] r, input logic [8:0] m,
                             input logic [8:0] n, input logic [2:0] d);
        drain();
        write_reg(REG_RADIUS, 64'(r));
        write_reg(REG_MIN_NB, 64'(m));
        write_reg(REG_NPTS, 64'(n));
        write_reg(REG_DIMS, 64'(d));
    endtask

    // points gather around a few centers, with some far outliers
    task automatic load_clustered(input logic [7:0] idx);
        logic signed [15:0] c [4];
        int ctr;
        ctr = $urandom_range(3);
        foreach (c[d]) begin
            if ($urandom_range(9) == 0) c[d] = 16'($urandom);
            else c[d] = 16'(ctr * 4000 - 6000 + int'($urandom_range(120)) - 60);
        end
        send_item(OP_LOAD, idx, c);
    endtask

    task automatic test_preload();
        configure(34'd10000, 9'd2, 9'd16, 3'd2);
        for (int i = 0; i < NLOAD; i++) load_clustered(i[7:0]);
    endtask

    task automatic test_directed();
        logic signed [15:0] hi [4];
        logic signed [15:0] lo [4];
        foreach (hi[d]) begin
            hi[d] = 16'sh7fff;
            lo[d] = 16'sh8000;
        end
        send_item(OP_LOAD, 8'd0, hi);
        send_item(OP_LOAD, 8'd1, lo);
        send_op(OP_READ, 8'd0);
        send_op(OP_READ, 8'd255);
        load_clustered(8'd200);
        send_op(OP_UNUSED, 8'd5);
        send_op(OP_RUN, 8'd0);
        for (int i = 0; i < 6; i++) send_op(OP_READ, i[7:0]);
        send_op(OP_READ, 8'd16);
        send_op(OP_UNUSED, 8'd255);
        send_item(OP_LOAD, 8'd255, hi);
    endtask

    task automatic test_config_extremes();
        configure(34'd0, 9'd0, 9'd12, 3'd0);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd3);
        configure(34'h3_ffff_ffff, 9'd0, 9'd20, 3'd7);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd1);
        send_op(OP_READ, 8'd19);
        configure(34'h3_ffff_ffff, 9'd256, 9'd20, 3'd4);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd7);
        configure(34'h3_ffff_ffff, 9'd19, 9'd20, 3'd4);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd12);
        configure(34'd20000, 9'd511, 9'd511, 3'd1);
        send_op(OP_READ, 8'd255);
        send_op(OP_READ, 8'd128);
        configure(34'd20000, 9'd511, 9'd0, 3'd1);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd0);
        configure(34'd1, 9'd1, 9'd1, 3'd3);
        send_op(OP_RUN, 8'd0);
        send_op(OP_READ, 8'd0);
    endtask

    task automatic random_phase(input int idle, input int stall, input int count);
        int sel;
        int n;
        configure(34'($urandom_range(40000, 2000)), 9'($urandom_range(4, 1)),
                  9'($urandom_range(NLOAD, 8)), 3'($urandom_range(4, 1)));
        send_idle_pct = idle;
        stall_pct = stall;
        n = eff_points();
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 10) send_op(OP_RUN, 8'($urandom));
            else if (sel < 30) load_clustered(8'($urandom_range(n - 1)));
            else if (sel < 35) send_op(OP_LOAD, 8'($urandom));
            else if (sel < 40) send_op(OP_UNUSED, 8'($urandom));
            else if (sel < 85) send_op(OP_READ, 8'($urandom_range(n - 1)));
            else send_op(OP_READ, 8'($urandom));
        end
        send_op(OP_RUN, 8'd0);
        drain();
    endtask

    initial begin
        radius_sq = '0;
        min_nb = 9'd4;
        npts_cfg = 9'd256;
        dims_cfg = 3'd3;
        cluster_total = 0;
        foreach (labels[i]) labels[i] = LABEL_UNCLASS;
        foreach (coords[i, d]) coords[i][d] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_preload();
        test_directed();
        test_config_extremes();
        random_phase(0, 0, 10);
        random_phase(59, 0, 10);
        random_phase(0, 59, 10);
        random_phase(37, 37, 10);
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
